// File: rtl/core/decimal_amount_text_parser_defines.svh
// Assertion macros shared by the decimal amount parser RTL.
`ifndef DECIMAL_AMOUNT_TEXT_PARSER_DEFINES_SVH
`define DECIMAL_AMOUNT_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DAP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dap_pkg.sv
// Types and constants for the decimal amount text parser.
`default_nettype none
package dap_pkg;

   localparam int AMOUNT_W = 64;
   localparam int STATUS_W = 3;
   localparam int CHAR_W   = 8;
   localparam int WHOLE_W  = 57;
   localparam int FRAC_W   = 7;

   // Largest whole part whose value in hundredths still fits in 63 bits.
   localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 57'd92233720368547758;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LONE_SIGN = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 3'd5;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;

   typedef struct packed {
      logic              req_type;
      logic [CHAR_W-1:0] char_code;
   } dap_req_type;

   typedef struct packed {
      logic signed [AMOUNT_W-1:0] amount;
      logic [STATUS_W-1:0]        status;
   } dap_rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/dap_core.sv
// Parser state and per-character update, with the end-of-text result.
`default_nettype none
module dap_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  dap_pkg::dap_req_type item,
   output dap_pkg::dap_rsp_type result
);
   import dap_pkg::*;

   typedef enum logic [1:0] {PH_START, PH_SIGN, PH_WHOLE, PH_FRAC} phase_type;

   localparam int NEXT_W = WHOLE_W + 4;

   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [WHOLE_W-1:0]    whole_ff, whole_in;
   logic [AMOUNT_W-1:0]   cent_ff, cent_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [1:0]            fcount_ff, fcount_in;
   logic                  saw_ff, saw_in;
   logic [STATUS_W-1:0]   err_ff, err_in;

   logic                  is_digit;
   logic [3:0]            digit;
   logic [9:0]            digit_x100;
   logic [NEXT_W-1:0]     whole_wide;
   logic [NEXT_W-1:0]     whole_next;
   logic                  whole_over;
   logic [AMOUNT_W-1:0]   cent_next;
   logic [FRAC_W-1:0]     frac_next;
   logic                  pending;
   logic [FRAC_W-1:0]     frac_val;
   logic [AMOUNT_W-1:0]   total;
   logic [STATUS_W-1:0]   status;

   always_comb begin
      is_digit   = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
      digit      = 4'(item.char_code - CHAR_ZERO);
      digit_x100 = ({6'b0, digit} << 6) + ({6'b0, digit} << 5) + ({6'b0, digit} << 2);
      whole_wide = NEXT_W'(whole_ff);
      whole_next = (whole_wide << 3) + (whole_wide << 1) + NEXT_W'(digit);
      whole_over = whole_next > NEXT_W'(WHOLE_LIMIT);
      // Exact whenever the whole part stays in range, so truncation is harmless.
      cent_next  = (cent_ff << 3) + (cent_ff << 1) + AMOUNT_W'(digit_x100);
      frac_next  = (frac_ff << 3) + (frac_ff << 1) + {3'b0, digit};
      pending    = (err_ff != ST_OK) && (err_ff != ST_OVERFLOW);

      // a single fraction digit counts as tenths
      frac_val = (fcount_ff == 2'd1) ? ((frac_ff << 3) + (frac_ff << 1)) : frac_ff;
      total    = cent_ff + AMOUNT_W'(frac_val);

      if (pending) begin
         status = err_ff;
      end else if (phase_ff == PH_START) begin
         status = ST_EMPTY;
      end else if (phase_ff == PH_SIGN) begin
         status = ST_LONE_SIGN;
      end else if (!saw_ff) begin
         status = ST_NO_DIGITS;
      end else if (err_ff == ST_OVERFLOW || total[AMOUNT_W-1]) begin
         status = ST_OVERFLOW;
      end else begin
         status = ST_OK;
      end

      result.status = status;
      if (status != ST_OK) begin
         result.amount = '0;
      end else if (neg_ff) begin
         result.amount = -total;
      end else begin
         result.amount = total;
      end

      phase_in  = phase_ff;
      neg_in    = neg_ff;
      whole_in  = whole_ff;
      cent_in   = cent_ff;
      frac_in   = frac_ff;
      fcount_in = fcount_ff;
      saw_in    = saw_ff;
      err_in    = err_ff;

      if (step_en && item.req_type == REQ_END) begin
         phase_in  = PH_START;
         neg_in    = 1'b0;
         whole_in  = '0;
         cent_in   = '0;
         frac_in   = '0;
         fcount_in = '0;
         saw_in    = 1'b0;
         err_in    = ST_OK;
      end else if (step_en && !pending) begin
         // first structural error wins; later characters are dropped
         if (phase_ff == PH_FRAC) begin
            if (!is_digit) begin
               err_in = ST_BAD_CHAR;
            end else if (fcount_ff >= 2'd2) begin
               err_in = ST_TOO_MANY;
            end else begin
               frac_in   = frac_next;
               fcount_in = fcount_ff + 2'd1;
               saw_in    = 1'b1;
            end
         end else if (phase_ff == PH_START &&
                      (item.char_code == CHAR_PLUS || item.char_code == CHAR_MINUS)) begin
            neg_in   = (item.char_code == CHAR_MINUS);
            phase_in = PH_SIGN;
         end else if (item.char_code == CHAR_POINT) begin
            phase_in = PH_FRAC;
         end else if (is_digit) begin
            saw_in   = 1'b1;
            phase_in = PH_WHOLE;
            if (err_ff != ST_OVERFLOW) begin
               if (whole_over) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  whole_in = whole_next[WHOLE_W-1:0];
                  cent_in  = cent_next;
               end
            end
         end else begin
            err_in = ST_BAD_CHAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         neg_ff    <= 1'b0;
         whole_ff  <= '0;
         cent_ff   <= '0;
         frac_ff   <= '0;
         fcount_ff <= '0;
         saw_ff    <= 1'b0;
         err_ff    <= ST_OK;
      end else begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         whole_ff  <= whole_in;
         cent_ff   <= cent_in;
         frac_ff   <= frac_in;
         fcount_ff <= fcount_in;
         saw_ff    <= saw_in;
         err_ff    <= err_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/decimal_amount_text_parser.sv
// Top level of the decimal amount text parser: input register, parser, result register.
// An end item's result passes through the input register and then the result register to rsp_valid.
// Throughput: one item per cycle, but an end item held while a result is stalled holds back every later item.
// Reset is synchronous and clears both handshakes and all parser state.
`default_nettype none
`include "decimal_amount_text_parser_defines.svh"
module decimal_amount_text_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dap_pkg::dap_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dap_pkg::dap_rsp_type rsp_data
);
   import dap_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   dap_req_type hold_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   dap_rsp_type rsp_data_ff;
   dap_rsp_type core_result;
   logic        hold_go;
   logic        req_take;

   // characters never wait; an end item waits only for a free result register
   assign hold_go   = hold_valid_ff &&
                      (hold_data_ff.req_type == REQ_CHAR || !rsp_valid_ff || rsp_ready);
   assign req_ready = !hold_valid_ff || hold_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      hold_valid_in = req_take ? 1'b1 : (hold_go ? 1'b0 : hold_valid_ff);
      if (hold_go && hold_data_ff.req_type == REQ_END) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   dap_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (hold_go),
      .item    (hold_data_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (req_take) begin
         hold_data_ff <= req_data;
      end
      if (hold_go && hold_data_ff.req_type == REQ_END) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DAP_ASSERT_NOW(a_amount_zero_on_error, clock, reset,
      rsp_valid_ff && rsp_data_ff.status != ST_OK, rsp_data_ff.amount == '0,
      "non-zero amount with error status")
   `DAP_ASSERT_NEXT(a_result_from_end_item, clock, reset,
      !(hold_go && hold_data_ff.req_type == REQ_END), !$rose(rsp_valid_ff),
      "result raised without an end item")
   `DAP_ASSERT_NOW(a_end_waits_for_slot, clock, reset,
      rsp_valid_ff && !rsp_ready && hold_valid_ff && hold_data_ff.req_type == REQ_END,
      !hold_go, "end item processed over a pending result")

endmodule
`default_nettype wire

// File: tb/decimal_amount_text_parser_test.sv
// Self-checking testbench for the decimal amount text parser: directed texts, then random ones.
module decimal_amount_text_parser_test;
   import dap_pkg::*;

   localparam int RANDOM_ITEMS = 1190;
   localparam int DRAIN_CYCLES = 16;
   // Sized for the worst case of every item behind the longest gap, plus result stalls.
   localparam int CYCLE_LIMIT  = 600_000;
   localparam logic signed [AMOUNT_W-1:0] AMOUNT_TOP = 64'sd9223372036854775807;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_SIGN, SCAN_WHOLE, SCAN_FRAC} scan_phase_type;

   typedef struct {
      string                      text;
      bit                         has_tail;
      logic [CHAR_W-1:0]          tail;
      bit                         typed;
      logic [STATUS_W-1:0]        status;
      logic signed [AMOUNT_W-1:0] amount;
   } probe_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   dap_req_type req_data  = '0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   dap_rsp_type rsp_data;

   // Parser state mirrored on the testbench side.
   scan_phase_type      scan_phase;
   logic                neg_seen;
   logic [63:0]         whole_val;
   logic [FRAC_W-1:0]   frac_val;
   logic [1:0]          frac_digits;
   logic                digit_seen;
   logic [STATUS_W-1:0] pending_err;

   dap_rsp_type       awaited_amounts[$];
   logic [CHAR_W-1:0] text_q[$];
   int                items_sent  = 0;
   int                fault_count = 0;
   int                cycle_count = 0;
   bit                burst_mode  = 1'b0;

   probe_row_type probes[0:21] = '{
      '{"",                      1'b0, 8'h00, 1'b1, ST_EMPTY,     64'sd0},
      '{"-",                     1'b0, 8'h00, 1'b1, ST_LONE_SIGN, 64'sd0},
      '{"+.",                    1'b0, 8'h00, 1'b1, ST_NO_DIGITS, 64'sd0},
      '{".",                     1'b0, 8'h00, 1'b1, ST_NO_DIGITS, 64'sd0},
      '{".5",                    1'b0, 8'h00, 1'b1, ST_OK,        64'sd50},
      '{"5.",                    1'b0, 8'h00, 1'b1, ST_OK,        64'sd500},
      '{"-0",                    1'b0, 8'h00, 1'b1, ST_OK,        64'sd0},
      '{"+9.9",                  1'b0, 8'h00, 1'b0, ST_OK,        64'sd0},
      '{"-12.34",                1'b0, 8'h00, 1'b1, ST_OK,        -64'sd1234},
      '{"-.1",                   1'b0, 8'h00, 1'b0, ST_OK,        64'sd0},
      '{"1.234.",                1'b0, 8'h00, 1'b1, ST_TOO_MANY,  64'sd0},
      '{"",                      1'b1, 8'h00, 1'b1, ST_BAD_CHAR,  64'sd0},
      '{"7",                     1'b1, 8'hff, 1'b1, ST_BAD_CHAR,  64'sd0},
      '{"9:/",                   1'b0, 8'h00, 1'b1, ST_BAD_CHAR,  64'sd0},
      '{"1-",                    1'b0, 8'h00, 1'b1, ST_BAD_CHAR,  64'sd0},
      '{"--1",                   1'b0, 8'h00, 1'b1, ST_BAD_CHAR,  64'sd0},
      '{"1..",                   1'b0, 8'h00, 1'b1, ST_BAD_CHAR,  64'sd0},
      '{"92233720368547758.07",  1'b0, 8'h00, 1'b1, ST_OK,        AMOUNT_TOP},
      '{"-92233720368547758.07", 1'b0, 8'h00, 1'b1, ST_OK,        -AMOUNT_TOP},
      '{"92233720368547758.08",  1'b0, 8'h00, 1'b1, ST_OVERFLOW,  64'sd0},
      '{"922337203685477580",    1'b0, 8'h00, 1'b1, ST_OVERFLOW,  64'sd0},
      '{"922337203685477580a",   1'b0, 8'h00, 1'b1, ST_BAD_CHAR,  64'sd0}
   };

   decimal_amount_text_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic void clear_amount_parser();
      scan_phase  = SCAN_IDLE;
      neg_seen    = 1'b0;
      whole_val   = '0;
      frac_val    = '0;
      frac_digits = '0;
      digit_seen  = 1'b0;
      pending_err = ST_OK;
   endfunction

   // The first structural error sticks; a pending overflow gives way to one.
   function automatic void flag_structural(input logic [STATUS_W-1:0] code);
      if (pending_err == ST_OK || pending_err == ST_OVERFLOW)
         pending_err = code;
   endfunction

   function automatic bit parse_amount_item(input dap_req_type it, output dap_rsp_type res);
      logic [CHAR_W-1:0] c;
      bit                is_digit;
      logic [63:0]       digit;
      logic [63:0]       grown;
      logic [63:0]       frac;
      logic [63:0]       total;
      c        = it.char_code;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      digit    = is_digit ? 64'(c - CHAR_ZERO) : 64'd0;
      res      = '0;
      if (it.req_type == REQ_CHAR) begin
         if (pending_err != ST_OK && pending_err != ST_OVERFLOW)
            return 1'b0;
         if (scan_phase == SCAN_FRAC) begin
            if (!is_digit) begin
               flag_structural(ST_BAD_CHAR);
            end else if (frac_digits >= 2) begin
               flag_structural(ST_TOO_MANY);
            end else begin
               frac_val    = FRAC_W'(frac_val * 10 + digit);
               frac_digits = frac_digits + 2'd1;
               digit_seen  = 1'b1;
            end
         end else if (scan_phase == SCAN_IDLE && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            neg_seen   = (c == CHAR_MINUS);
            scan_phase = SCAN_SIGN;
         end else if (c == CHAR_POINT) begin
            scan_phase = SCAN_FRAC;
         end else if (is_digit) begin
            digit_seen = 1'b1;
            // Once overflowed the whole part is frozen.
            if (pending_err != ST_OVERFLOW) begin
               grown = whole_val * 64'd10 + digit;
               if (grown > 64'(WHOLE_LIMIT))
                  pending_err = ST_OVERFLOW;
               else
                  whole_val = grown;
            end
            scan_phase = SCAN_WHOLE;
         end else begin
            flag_structural(ST_BAD_CHAR);
         end
         return 1'b0;
      end
      if (pending_err != ST_OK && pending_err != ST_OVERFLOW) begin
         res.status = pending_err;
      end else if (scan_phase == SCAN_IDLE) begin
         res.status = ST_EMPTY;
      end else if (scan_phase == SCAN_SIGN) begin
         res.status = ST_LONE_SIGN;
      end else if (!digit_seen) begin
         res.status = ST_NO_DIGITS;
      end else if (pending_err == ST_OVERFLOW) begin
         res.status = ST_OVERFLOW;
      end else begin
         // A lone fraction digit is tenths.
         frac  = (frac_digits == 2'd1) ? 64'(frac_val) * 64'd10 : 64'(frac_val);
         total = whole_val * 64'd100 + frac;
         if (total > 64'(AMOUNT_TOP)) begin
            res.status = ST_OVERFLOW;
         end else begin
            res.status = ST_OK;
            res.amount = neg_seen ? -total : total;
         end
      end
      clear_amount_parser();
      return 1'b1;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void append_char(input logic [CHAR_W-1:0] ch);
      text_q.insert(text_q.size(), ch);
   endfunction

   function automatic void add_digits(input int n);
      repeat (n)
         append_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
   endfunction

   function automatic void build_wellformed();
      int    r;
      string near_top;
      near_top = "9223372036854775";
      text_q.delete();
      r = $urandom_range(0, 3);
      if (r == 0)
         append_char(CHAR_PLUS);
      else if (r == 1)
         append_char(CHAR_MINUS);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // hover around the largest whole part
         for (int k = 0; k < near_top.len(); k++)
            append_char(near_top[k]);
         add_digits($urandom_range(1, 3));
      end else if (r < 20) begin
         add_digits(0);
      end else if (r < 85) begin
         add_digits($urandom_range(1, 4));
      end else if (r < 95) begin
         add_digits($urandom_range(5, 12));
      end else begin
         add_digits($urandom_range(16, 19));
      end
      if ($urandom_range(0, 9) < 6) begin
         append_char(CHAR_POINT);
         r = $urandom_range(0, 9);
         add_digits(r < 2 ? 0 : (r < 5 ? 1 : 2));
      end
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch: %s", msg);
   endfunction

   task automatic feed_item(input dap_req_type it, input bit typed, input dap_rsp_type typed_rsp);
      int          gap;
      dap_rsp_type predicted;
      gap = pick_gap(burst_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (parse_amount_item(it, predicted))
         awaited_amounts.insert(awaited_amounts.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic issue_text(input logic [CHAR_W-1:0] chars[$], input bit typed,
                             input dap_rsp_type want);
      dap_req_type it;
      foreach (chars[i]) begin
         it.req_type  = REQ_CHAR;
         it.char_code = chars[i];
         feed_item(it, 1'b0, want);
      end
      // char_code on the end item should be ignored, so scramble it
      it.req_type  = REQ_END;
      it.char_code = CHAR_W'($urandom_range(0, 255));
      feed_item(it, typed, want);
   endtask

   // Result side back-pressure, with the odd long stretch of none.
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (run_left > 0) begin
               run_left--;
            end else if ($urandom_range(0, 9) == 0) begin
               run_left = $urandom_range(20, 80);
            end else begin
               stall_left = pick_gap(1'b0);
               run_left   = $urandom_range(0, 4);
            end
         end
      end
   end

   always @(posedge clock) begin
      dap_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_amounts.size() == 0) begin
            note_fault($sformatf("unexpected result amount %0d status %0d",
                                 rsp_data.amount, rsp_data.status));
         end else begin
            want = awaited_amounts.pop_front();
            if (rsp_data.amount !== want.amount)
               note_fault($sformatf("amount expected %0d got %0d", want.amount, rsp_data.amount));
            if (rsp_data.status !== want.status)
               note_fault($sformatf("status expected %0d got %0d", want.status, rsp_data.status));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      dap_rsp_type want;
      int          directed_items;
      int          r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      clear_amount_parser();

      foreach (probes[i]) begin
         text_q.delete();
         for (int k = 0; k < probes[i].text.len(); k++)
            append_char(probes[i].text[k]);
         if (probes[i].has_tail)
            append_char(probes[i].tail);
         want.amount = probes[i].amount;
         want.status = probes[i].status;
         issue_text(text_q, probes[i].typed, want);
      end
      directed_items = items_sent;

      want = '0;
      while (items_sent - directed_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0)
            burst_mode = !burst_mode;
         r = $urandom_range(0, 99);
         if (r < 70) begin
            build_wellformed();
         end else if (r < 90) begin
            // well-formed text with one possible defect planted in it
            build_wellformed();
            r = $urandom_range(0, 3);
            if (r == 0) begin
               text_q.insert($urandom_range(0, text_q.size()), CHAR_W'($urandom_range(0, 255)));
            end else if (r == 1) begin
               append_char(CHAR_POINT);
               add_digits($urandom_range(3, 4));
            end else if (r == 2) begin
               text_q.insert($urandom_range(0, text_q.size()),
                             $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            end else begin
               text_q.insert($urandom_range(0, text_q.size()), CHAR_POINT);
            end
         end else begin
            text_q.delete();
            repeat ($urandom_range(0, 5)) begin
               r = $urandom_range(0, 12);
               if ($urandom_range(0, 1))
                  append_char(CHAR_W'($urandom_range(0, 255)));
               else if (r < 10)
                  append_char(CHAR_ZERO + CHAR_W'(r));
               else
                  append_char(r == 10 ? CHAR_PLUS : (r == 11 ? CHAR_MINUS : CHAR_POINT));
            end
         end
         issue_text(text_q, 1'b0, want);
      end
      req_valid <= 1'b0;

      while (awaited_amounts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && awaited_amounts.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: decimal_amount_text_parser.f
+incdir+rtl/core
rtl/core/dap_pkg.sv
rtl/core/dap_core.sv
rtl/core/decimal_amount_text_parser.sv
tb/decimal_amount_text_parser_test.sv
